// ===== rtl/rau_pkg.sv =====
// Shared types and codes for the rational arithmetic unit.
package rau_pkg;

  localparam int DefaultWidth = 32;

  localparam logic [2:0] CMD_ADD   = 3'd0;
  localparam logic [2:0] CMD_SUB   = 3'd1;
  localparam logic [2:0] CMD_MUL   = 3'd2;
  localparam logic [2:0] CMD_DIV   = 3'd3;
  localparam logic [2:0] CMD_NEG   = 3'd4;
  localparam logic [2:0] CMD_RECIP = 3'd5;
  localparam logic [2:0] CMD_CMP   = 3'd6;

  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_INV = 2'd1;
  localparam logic [1:0] ST_OVF    = 2'd2;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] left_num;
    logic [30:0]        left_den;
    logic signed [31:0] right_num;
    logic [30:0]        right_den;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_num;
    logic [30:0]        result_den;
    logic [1:0]         order;
    logic [1:0]         status;
  } out_t;

endpackage

// ===== rtl/rational_arithmetic_unit_top.sv =====
// Rational arithmetic unit: sequencer around a shared multiplier, GCD stepper and divider.
//
// Usage: a transaction on the input channel (in_valid/in_ready, payload in_data)
// carries a command and two fractions; exactly one transaction on the output
// channel (out_valid/out_ready, payload out_data) returns the reduced result,
// the compare outcome and a status code.
// Latency depends on the command and the operands. Negate and reciprocal take
// one binary GCD run on 32-bit operands and two divisions. Multiply and divide
// form two products and then reduce a 64-bit product by a GCD run and two
// divisions. Compare stops after the multiplier. Add and subtract first run a
// GCD and two divisions on the denominators, then form three products and do
// the final reduction. The restoring divider and the subtract-and-shift GCD
// loop set the latency.
// One transaction is worked on at a time; in_ready is high only while the unit
// is idle. A finished result sits in the output register until it is taken,
// and the next transaction may be accepted meanwhile; if the receiver stalls,
// the following result waits in the sequencer until the register frees.
// Reset is synchronous and returns the sequencer to idle with no result held.
module rational_arithmetic_unit_top
  import rau_pkg::*;
#(
  parameter int WIDTH = DefaultWidth
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_MUL, S_COMB, S_PREP, S_GCD, S_DIV, S_FIN, S_EMIT
  } state_t;

  // Largest positive value a reduced result may have in WIDTH bits; a negative numerator may reach one more.
  localparam logic [63:0] MaxPos = (64'd1 << (WIDTH - 1)) - 64'd1;

  state_t state;

  // Latched operands; a zero denominator is taken as one.
  logic [2:0]         cmd;
  logic signed [31:0] ln, rn;
  logic [30:0]        ld, rd;

  // Products, working fraction and reduction registers.
  logic signed [63:0] pa, pb, pc;
  logic signed [63:0] n;
  logic [63:0]        d, mag;
  logic               neg;
  logic [63:0]        ga, gb, g, q1, q2;
  logic [5:0]         gsh;
  logic [63:0]        drem, dquo, ddiv;
  logic [5:0]         dcnt;
  logic               dsel;
  logic               lcm_phase;
  logic [1:0]         mstep;
  out_t               res;

  // Shared signed multiplier.
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  always_comb begin
    mul_a = 33'(ln);
    mul_b = 33'(rn);
    case (cmd)
      CMD_ADD, CMD_SUB: begin
        case (mstep)
          2'd0: begin mul_a = 33'(ln); mul_b = $signed({1'b0, q2[31:0]}); end
          2'd1: begin mul_a = 33'(rn); mul_b = $signed({1'b0, q1[31:0]}); end
          default: begin
            mul_a = $signed({1'b0, q1[31:0]});
            mul_b = $signed({2'b00, rd});
          end
        endcase
      end
      CMD_MUL: begin
        if (mstep == 2'd0) begin
          mul_a = 33'(ln); mul_b = 33'(rn);
        end else begin
          mul_a = $signed({2'b00, ld}); mul_b = $signed({2'b00, rd});
        end
      end
      CMD_DIV: begin
        if (mstep == 2'd0) begin
          mul_a = 33'(ln); mul_b = $signed({2'b00, rd});
        end else begin
          mul_a = $signed({2'b00, ld}); mul_b = 33'(rn);
        end
      end
      default: begin
        if (mstep == 2'd0) begin
          mul_a = 33'(ln); mul_b = $signed({2'b00, rd});
        end else begin
          mul_a = 33'(rn); mul_b = $signed({2'b00, ld});
        end
      end
    endcase
    prod = mul_a * mul_b;
  end

  logic [1:0] mlast;
  assign mlast = (cmd == CMD_ADD || cmd == CMD_SUB) ? 2'd2 : 2'd1;

  // Binary GCD step.
  logic        gcd_done;
  logic [63:0] gval;
  assign gcd_done = (ga == 64'd0) || (gb == 64'd0);
  assign gval     = (ga | gb) << gsh;

  // Restoring divider step.
  logic [64:0] rem_sh;
  logic        div_ge;
  logic [63:0] rem_nx, quo_nx;
  assign rem_sh = {drem, dquo[63]};
  assign div_ge = rem_sh >= {1'b0, ddiv};
  assign rem_nx = div_ge ? 64'(rem_sh - {1'b0, ddiv}) : rem_sh[63:0];
  assign quo_nx = {dquo[62:0], div_ge};

  logic [63:0] nmag;
  assign nmag = n[63] ? 64'(-n) : 64'(n);

  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd   <= in_data.cmd;
            ln    <= in_data.left_num;
            rn    <= in_data.right_num;
            ld    <= (in_data.left_den == 31'd0) ? 31'd1 : in_data.left_den;
            rd    <= (in_data.right_den == 31'd0) ? 31'd1 : in_data.right_den;
            state <= S_START;
          end
        end
        S_START: begin
          res.result_num <= 32'sd0;
          res.result_den <= 31'd1;
          res.order      <= ORD_EQ;
          res.status     <= ST_OK;
          mstep          <= 2'd0;
          gsh            <= 6'd0;
          case (cmd)
            CMD_ADD, CMD_SUB: begin
              ga        <= {33'd0, ld};
              gb        <= {33'd0, rd};
              lcm_phase <= 1'b1;
              state     <= S_GCD;
            end
            CMD_MUL, CMD_CMP: state <= S_MUL;
            CMD_DIV: begin
              if (rn == 32'sd0) begin
                res.status <= ST_NO_INV;
                state      <= S_EMIT;
              end else begin
                state <= S_MUL;
              end
            end
            CMD_NEG: begin
              n     <= -64'(ln);
              d     <= {33'd0, ld};
              state <= S_PREP;
            end
            CMD_RECIP: begin
              if (ln == 32'sd0) begin
                res.status <= ST_NO_INV;
                state      <= S_EMIT;
              end else begin
                n     <= ln[31] ? -$signed({33'd0, ld}) : $signed({33'd0, ld});
                d     <= ln[31] ? 64'(-64'(ln)) : 64'(64'(ln));
                state <= S_PREP;
              end
            end
            default: state <= S_EMIT;
          endcase
        end
        S_MUL: begin
          case (mstep)
            2'd0:    pa <= prod[63:0];
            2'd1:    pb <= prod[63:0];
            default: pc <= prod[63:0];
          endcase
          mstep <= mstep + 2'd1;
          if (mstep == mlast) state <= S_COMB;
        end
        S_COMB: begin
          state <= S_PREP;
          case (cmd)
            CMD_ADD: begin n <= pa + pb; d <= pc; end
            CMD_SUB: begin n <= pa - pb; d <= pc; end
            CMD_MUL: begin n <= pa; d <= pb; end
            CMD_DIV: begin
              n <= pb[63] ? -pa : pa;
              d <= pb[63] ? 64'(-pb) : 64'(pb);
            end
            default: begin
              res.order <= (pa < pb) ? ORD_LT : ((pa > pb) ? ORD_GT : ORD_EQ);
              state     <= S_EMIT;
            end
          endcase
        end
        S_PREP: begin
          neg <= n[63];
          mag <= nmag;
          if (nmag == 64'd0) begin
            state <= S_EMIT;
          end else begin
            ga        <= nmag;
            gb        <= d;
            gsh       <= 6'd0;
            lcm_phase <= 1'b0;
            state     <= S_GCD;
          end
        end
        S_GCD: begin
          if (gcd_done) begin
            g     <= gval;
            ddiv  <= gval;
            drem  <= 64'd0;
            dquo  <= lcm_phase ? {33'd0, ld} : mag;
            dcnt  <= 6'd0;
            dsel  <= 1'b0;
            state <= S_DIV;
          end else if (!ga[0] && !gb[0]) begin
            ga  <= ga >> 1;
            gb  <= gb >> 1;
            gsh <= gsh + 6'd1;
          end else if (!ga[0]) begin
            ga <= ga >> 1;
          end else if (!gb[0]) begin
            gb <= gb >> 1;
          end else if (ga >= gb) begin
            ga <= ga - gb;
          end else begin
            gb <= gb - ga;
          end
        end
        S_DIV: begin
          drem <= rem_nx;
          dquo <= quo_nx;
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd63) begin
            if (!dsel) begin
              q1   <= quo_nx;
              drem <= 64'd0;
              dquo <= lcm_phase ? {33'd0, rd} : d;
              ddiv <= g;
              dsel <= 1'b1;
            end else begin
              q2    <= quo_nx;
              mstep <= 2'd0;
              state <= lcm_phase ? S_MUL : S_FIN;
            end
          end
        end
        S_FIN: begin
          if (q2 > MaxPos || q1 > (MaxPos + {63'd0, neg})) begin
            res.status <= ST_OVF;
          end else begin
            res.result_num <= neg ? -$signed(q1[31:0]) : $signed(q1[31:0]);
            res.result_den <= q2[30:0];
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Any error or a compare outcome leaves the fraction fields at zero over one.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |->
      out_data.result_num == 32'sd0 && out_data.result_den == 31'd1)
    else $error("error result carries a fraction");

  a_cmp_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.order != ORD_EQ |->
      out_data.result_num == 32'sd0 && out_data.status == ST_OK)
    else $error("compare result carries a fraction");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> ddiv != 64'd0)
    else $error("divider started with a zero divisor");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_START)
    else $error("accepted transaction not started");

endmodule

// ===== tb/sv/rational_arithmetic_unit_top_tb.sv =====
// Self-checking testbench for the rational arithmetic unit: directed, random and back-pressure tests.
module rational_arithmetic_unit_top_tb;
  import rau_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The drain period at the end allows a little more than the slowest transaction
  // (add or subtract) takes.
  localparam int DrainCycles = 700;
  // Around 1900 transactions, each at its worst-case latency, plus sender gaps
  // and receiver stalls, stay well under this bound.
  localparam longint CycleLimit = 64'd8_000_000;
  localparam longint unsigned MaxMag = (64'd1 << 31) - 64'd1;
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int HoldOffCycles = 3000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  // Results predicted for accepted transactions, oldest first.
  out_t   expected_results[$];
  int     error_count = 0;
  longint cycle_count = 0;
  int     send_idle_pct;
  int     recv_stall_pct;
  int     hold_off_cycles;
  // A change of hold_off_req asks the receiver for one long hold-off.
  logic   hold_off_req;
  logic   hold_off_seen;

  rational_arithmetic_unit_top dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Free-running clock with a 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Euclidean greatest common divisor of two magnitudes.
  function automatic longint unsigned euclid_gcd(longint unsigned a, longint unsigned b);
    longint unsigned r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return euclid_gcd_ret(a);
  endfunction

  function automatic longint unsigned euclid_gcd_ret(longint unsigned a);
    return a;
  endfunction

  // Builds a result record from its four fields.
  function automatic out_t make_result(longint unsigned num, longint unsigned den,
                                       logic [1:0] ord, logic [1:0] st);
    out_t r;
    r.result_num = num[31:0];
    r.result_den = den[30:0];
    r.order      = ord;
    r.status     = st;
    return r;
  endfunction

  // Reduces n/d (d positive) to lowest terms and flags a result that does not fit.
  function automatic out_t reduced_fraction(longint n, longint unsigned d);
    logic            neg;
    longint unsigned mag;
    longint unsigned g;
    longint unsigned limit;
    neg = (n < 0);
    mag = neg ? (64'd0 - longint'(n)) : longint'(n);
    if (mag == 0) return make_result(0, 1, ORD_EQ, ST_OK);
    g = euclid_gcd(mag, d);
    mag = mag / g;
    d = d / g;
    limit = neg ? MaxMag + 1 : MaxMag;
    if (d > MaxMag || mag > limit) return make_result(0, 1, ORD_EQ, ST_OVF);
    return make_result(neg ? (64'd0 - mag) : mag, d, ORD_EQ, ST_OK);
  endfunction

  // Computes the expected result of one command on two fractions.
  function automatic out_t rational_result(in_t x);
    longint ln, ld, rn, rd;
    longint lcm, a, b, n, d;
    longint unsigned g;
    ln = longint'(x.left_num);
    rn = longint'(x.right_num);
    // A zero denominator is taken as one.
    ld = (x.left_den == 0) ? 64'sd1 : longint'({33'd0, x.left_den});
    rd = (x.right_den == 0) ? 64'sd1 : longint'({33'd0, x.right_den});
    case (x.cmd)
      CMD_ADD, CMD_SUB: begin
        g   = euclid_gcd(ld, rd);
        lcm = (ld / longint'(g)) * rd;
        a   = ln * (lcm / ld);
        b   = rn * (lcm / rd);
        return reduced_fraction((x.cmd == CMD_ADD) ? a + b : a - b, lcm);
      end
      CMD_MUL: return reduced_fraction(ln * rn, ld * rd);
      CMD_DIV: begin
        if (rn == 0) return make_result(0, 1, ORD_EQ, ST_NO_INV);
        n = ln * rd;
        d = ld * rn;
        if (d < 0) begin
          n = -n;
          d = -d;
        end
        return reduced_fraction(n, d);
      end
      CMD_NEG: return reduced_fraction(-ln, ld);
      CMD_RECIP: begin
        if (ln == 0) return make_result(0, 1, ORD_EQ, ST_NO_INV);
        if (ln < 0) return reduced_fraction(-ld, -ln);
        return reduced_fraction(ld, ln);
      end
      CMD_CMP: begin
        a = ln * rd;
        b = rn * ld;
        return make_result(0, 1, (a < b) ? ORD_LT : ((a > b) ? ORD_GT : ORD_EQ), ST_OK);
      end
      default: return make_result(0, 1, ORD_EQ, ST_OK);
    endcase
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(string what);
    error_count++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // Receiver: ready is dropped at random, or held low for a counted hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_ready       <= 1'b0;
      hold_off_cycles <= 0;
      hold_off_seen   <= hold_off_req;
    end else if (hold_off_req != hold_off_seen) begin
      out_ready       <= 1'b0;
      hold_off_cycles <= HoldOffCycles;
      hold_off_seen   <= hold_off_req;
    end else if (hold_off_cycles > 0) begin
      out_ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Checks every output transaction against the oldest prediction.
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", out_data));
      end else begin
        want = expected_results.pop_front();
        if (out_data.result_num !== want.result_num)
          report_mismatch($sformatf("result_num %0d, expected %0d",
                                    out_data.result_num, want.result_num));
        if (out_data.result_den !== want.result_den)
          report_mismatch($sformatf("result_den %0d, expected %0d",
                                    out_data.result_den, want.result_den));
        if (out_data.order !== want.order)
          report_mismatch($sformatf("order %0d, expected %0d", out_data.order, want.order));
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_data.status, want.status));
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offers one transaction after a random gap and waits until it is accepted.
  // The valid line is only lowered when a gap actually follows, so that a
  // back-to-back transaction never sees two assignments in one time step.
  task automatic send_transaction(in_t item);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(rational_result(item));
  endtask

  function automatic in_t fraction_pair(logic [2:0] cmd, int ln, int ld, int rn, int rd);
    in_t x;
    x.cmd       = cmd;
    x.left_num  = ln;
    x.left_den  = ld[30:0];
    x.right_num = rn;
    x.right_den = rd[30:0];
    return x;
  endfunction

  // Random numerator: small values most often, so that results stay in range,
  // with wider and extreme values mixed in.
  function automatic logic [31:0] random_num();
    case ($urandom_range(9))
      0, 1, 2, 3: return 32'($signed($urandom_range(40)) - 20);
      4, 5:       return 32'($signed($urandom_range(65535)) - 32768);
      6:          return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default:    return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] random_den();
    case ($urandom_range(9))
      0, 1, 2, 3: return 31'($urandom_range(24));
      4, 5:       return 31'($urandom_range(65535));
      6:          return $urandom_range(1) ? 31'h7FFF_FFFF : 31'd0;
      default:    return 31'($urandom);
    endcase
  endfunction

  function automatic in_t random_transaction();
    in_t x;
    x.cmd       = ($urandom_range(49) == 0) ? CMD_UNUSED : 3'($urandom_range(6));
    x.left_num  = random_num();
    x.left_den  = random_den();
    x.right_num = random_num();
    x.right_den = random_den();
    return x;
  endfunction

  // Short directed list: each command, the boundaries and the special cases.
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_transaction(fraction_pair(CMD_ADD, 1, 2, 1, 3));
    send_transaction(fraction_pair(CMD_SUB, 1, 2, 1, 3));
    send_transaction(fraction_pair(CMD_SUB, 3, 4, 6, 8));
    send_transaction(fraction_pair(CMD_MUL, -2, 3, 9, 4));
    send_transaction(fraction_pair(CMD_DIV, 2, 3, -4, 9));
    send_transaction(fraction_pair(CMD_DIV, 5, 7, 0, 3));
    send_transaction(fraction_pair(CMD_NEG, 6, 4, 0, 1));
    // Negating the most negative numerator does not fit.
    send_transaction(fraction_pair(CMD_NEG, 32'sh8000_0000, 1, 0, 1));
    send_transaction(fraction_pair(CMD_RECIP, 0, 5, 1, 1));
    send_transaction(fraction_pair(CMD_RECIP, -6, 4, 1, 1));
    send_transaction(fraction_pair(CMD_RECIP, 32'sh8000_0000, 1, 1, 1));
    send_transaction(fraction_pair(CMD_CMP, 1, 3, 1, 2));
    send_transaction(fraction_pair(CMD_CMP, 2, 4, 1, 2));
    send_transaction(fraction_pair(CMD_CMP, -1, 3, -1, 2));
    send_transaction(fraction_pair(CMD_UNUSED, 7, 3, 5, 2));
    // Zero denominators are read as one.
    send_transaction(fraction_pair(CMD_ADD, 3, 0, 4, 0));
    send_transaction(fraction_pair(CMD_ADD, 32'sh7FFF_FFFF, 1, 32'sh7FFF_FFFF, 1));
    send_transaction(fraction_pair(CMD_ADD, 1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFE));
    send_transaction(fraction_pair(CMD_MUL, 32'sh8000_0000, 1, 32'sh8000_0000, 1));
    send_transaction(fraction_pair(CMD_MUL, 32'sh8000_0000, 1, 1, 1));
    send_transaction(fraction_pair(CMD_DIV, 32'sh7FFF_FFFF, 32'h7FFF_FFFF,
                                   32'sh8000_0000, 32'h7FFF_FFFF));
    send_transaction(fraction_pair(CMD_SUB, 0, 9, 0, 5));
    send_transaction(fraction_pair(CMD_CMP, 32'sh8000_0000, 32'h7FFF_FFFF,
                                   32'sh7FFF_FFFF, 1));
  endtask

  // Random transactions under one idling profile.
  task automatic test_random(int count, int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) send_transaction(random_transaction());
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering,
  // so the output register and the sequencer fill and in_ready stays low.
  task automatic test_back_pressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_req   <= !hold_off_req;
    repeat (12) send_transaction(random_transaction());
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    hold_off_req   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(460, 0, 0);
    test_random(460, 87, 0);
    test_random(460, 0, 87);
    test_back_pressure();
    test_random(460, 35, 35);

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== rational_arithmetic_unit_top.f =====
rtl/rau_pkg.sv
rtl/rational_arithmetic_unit_top.sv
tb/sv/rational_arithmetic_unit_top_tb.sv
